>>> hdl/pjr_pkg.sv
// Shared types and constants of the per-source delay, jitter and reorder block.
// Used by pjr_ctrl, pjr_dp and the top level; depends on nothing else.
package pjr_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned NUM_KINDS     = 8;
  localparam int unsigned CFG_IW        = 8;

  // Generator geometry and constants.
  localparam int unsigned MT_N  = 312;
  localparam int unsigned MT_M  = 156;
  localparam int unsigned MT_AW = 9;
  localparam logic [63:0] MT_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] MT_UPPER  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] MT_LOWER  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] SEED_MULT = 64'd6364136223846793005;

  localparam logic [11:0] JITTER_TICKS = 12'd1024;
  localparam logic [13:0] JITTER_SPAN  = 14'd2049;
  // Three spans keep the folded alternating digit sum non-negative.
  localparam logic [13:0] FOLD_BIAS    = 14'd6147;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_SEED_FIRST,
    CMD_SEED_MUL0,
    CMD_SEED_MUL1,
    CMD_SEED_MUL2,
    CMD_SEED_WRITE,
    CMD_TW_RDA,
    CMD_TW_RDB,
    CMD_TW_RDC,
    CMD_TW_WRITE,
    CMD_DR_ADDR,
    CMD_DR_TEMPER,
    CMD_DR_MOD,
    CMD_DR_MUL,
    CMD_DR_OFFSET,
    CMD_NOJIT,
    CMD_STORE,
    CMD_SC_START,
    CMD_SC_STEP,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic start;
    logic last;
    logic jit_nz;
    logic need_twist;
    logic idx_last;
    logic scan_done;
    logic emit_last;
    logic out_free;
  } stat_t;

  function automatic logic [63:0] kind_reset(input logic [2:0] k);
    logic [63:0] v;
    unique case (k)
      3'd1:    v = 64'd4294967296500000000;
      3'd2:    v = 64'd214748364850000000;
      3'd3:    v = 64'd214748364850000000;
      3'd4:    v = 64'd214748364950000000;
      3'd5:    v = 64'd85899345920000000;
      3'd7:    v = 64'd214748364900000000;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/per_source_delay_jitter_reorder.sv
// Top level of the per-source delay, jitter and reorder block.
// Depends on pjr_pkg, pjr_ctrl and pjr_dp.

// Measurements are loaded one word at a time and held until the word marked
// last arrives; the whole batch then leaves sorted stably by arrival time. Each
// word takes its source kind's lag and jitter half-width from the kind
// registers. With nonzero jitter a 64-bit Mersenne Twister word picks a tick
// from -1024 to 1024, and the offset is lag + tick * jitter / 1024 truncated
// toward zero; the arrival is the timestamp plus that offset, saturated to the
// signed 64-bit range. Every 312 draws the generator memory is refilled in
// place. A start word seeds the 312-entry memory, with one 64-bit multiply per
// entry split into three 32-bit products, before the word itself is handled.
// Emission scans the held arrivals once per result, through the single read
// port of the arrival memory. The input is stalled throughout. The configuration
// port is always ready and is meant to be written only while the block is idle.
module per_source_delay_jitter_reorder #(
  parameter int unsigned MAX_ITEMS = pjr_pkg::MAX_ITEMS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pjr_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [63:0]                cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       start_req_i,
  input  logic [63:0]                seed_i,
  input  logic [2:0]                 sensor_kind_i,
  input  logic signed [63:0]         time_ns_i,
  input  logic [15:0]                tag_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [15:0]                out_tag_o,
  output logic [2:0]                 out_kind_o,
  output logic signed [63:0]         out_time_ns_o,
  output logic signed [63:0]         arrival_ns_o,
  output logic                       overflow_o,
  output logic                       out_last_o
);

  pjr_pkg::cmd_e  cmd;
  pjr_pkg::stat_t stat;

  // The kind registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  pjr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pjr_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .start_req_i   (start_req_i),
    .seed_i        (seed_i),
    .sensor_kind_i (sensor_kind_i),
    .time_ns_i     (time_ns_i),
    .tag_i         (tag_i),
    .last_i        (last_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_tag_o     (out_tag_o),
    .out_kind_o    (out_kind_o),
    .out_time_ns_o (out_time_ns_o),
    .arrival_ns_o  (arrival_ns_o),
    .overflow_o    (overflow_o),
    .out_last_o    (out_last_o)
  );

  // An accepted word always keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a word without going busy");

  // A waiting result keeps its word until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_tag_o) && $stable(arrival_ns_o)))
    else $error("waiting result changed before it was taken");

  // A result is only loaded when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == pjr_pkg::CMD_EMIT) |-> stat.out_free)
    else $error("result loaded over a waiting one");

endmodule

>>> hdl/pjr_ctrl.sv
// Sequencer of the reorder block: walks seeding, refill, draw, store and emission.
// Depends on pjr_pkg for the command and status types.
module pjr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pjr_pkg::stat_t stat_i,
  output pjr_pkg::cmd_e  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_SEED0, ST_SMUL0, ST_SMUL1, ST_SMUL2, ST_SWR, ST_JCHK,
    ST_TRDA, ST_TRDB, ST_TRDC, ST_TWR, ST_DADDR, ST_DTEMP, ST_DMOD, ST_DMUL,
    ST_DOFF, ST_STORE, ST_SCSTART, ST_SCAN, ST_FETCH, ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = pjr_pkg::CMD_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = pjr_pkg::CMD_LOAD;
          state_d = ST_DISP;
        end
      end
      ST_DISP:  state_d = stat_i.start ? ST_SEED0 : ST_JCHK;
      ST_SEED0: begin
        cmd_o   = pjr_pkg::CMD_SEED_FIRST;
        state_d = ST_SMUL0;
      end
      ST_SMUL0: begin
        cmd_o   = pjr_pkg::CMD_SEED_MUL0;
        state_d = ST_SMUL1;
      end
      ST_SMUL1: begin
        cmd_o   = pjr_pkg::CMD_SEED_MUL1;
        state_d = ST_SMUL2;
      end
      ST_SMUL2: begin
        cmd_o   = pjr_pkg::CMD_SEED_MUL2;
        state_d = ST_SWR;
      end
      ST_SWR: begin
        cmd_o   = pjr_pkg::CMD_SEED_WRITE;
        state_d = stat_i.idx_last ? ST_JCHK : ST_SMUL0;
      end
      ST_JCHK: begin
        priority if (!stat_i.jit_nz) begin
          cmd_o   = pjr_pkg::CMD_NOJIT;
          state_d = ST_STORE;
        end else if (stat_i.need_twist) begin
          state_d = ST_TRDA;
        end else begin
          state_d = ST_DADDR;
        end
      end
      ST_TRDA: begin
        cmd_o   = pjr_pkg::CMD_TW_RDA;
        state_d = ST_TRDB;
      end
      ST_TRDB: begin
        cmd_o   = pjr_pkg::CMD_TW_RDB;
        state_d = ST_TRDC;
      end
      ST_TRDC: begin
        cmd_o   = pjr_pkg::CMD_TW_RDC;
        state_d = ST_TWR;
      end
      ST_TWR: begin
        cmd_o   = pjr_pkg::CMD_TW_WRITE;
        state_d = stat_i.idx_last ? ST_DADDR : ST_TRDA;
      end
      ST_DADDR: begin
        cmd_o   = pjr_pkg::CMD_DR_ADDR;
        state_d = ST_DTEMP;
      end
      ST_DTEMP: begin
        cmd_o   = pjr_pkg::CMD_DR_TEMPER;
        state_d = ST_DMOD;
      end
      ST_DMOD: begin
        cmd_o   = pjr_pkg::CMD_DR_MOD;
        state_d = ST_DMUL;
      end
      ST_DMUL: begin
        cmd_o   = pjr_pkg::CMD_DR_MUL;
        state_d = ST_DOFF;
      end
      ST_DOFF: begin
        cmd_o   = pjr_pkg::CMD_DR_OFFSET;
        state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o   = pjr_pkg::CMD_STORE;
        state_d = stat_i.last ? ST_SCSTART : ST_IDLE;
      end
      ST_SCSTART: begin
        cmd_o   = pjr_pkg::CMD_SC_START;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o = pjr_pkg::CMD_SC_STEP;
        if (stat_i.scan_done) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o   = pjr_pkg::CMD_EMIT;
          state_d = stat_i.emit_last ? ST_IDLE : ST_SCSTART;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = stall_q;

endmodule

>>> hdl/pjr_dp.sv
// Datapath of the reorder block: registers, generator memory, held-item memories,
// arithmetic and the output register. Depends on pjr_pkg; driven by pjr_ctrl.
module pjr_dp #(
  parameter int unsigned MAX_ITEMS = pjr_pkg::MAX_ITEMS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pjr_pkg::cmd_e              cmd_i,
  output pjr_pkg::stat_t             stat_o,
  input  logic                       cfg_we_i,
  input  logic [pjr_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [63:0]                cfg_data_i,
  input  logic                       start_req_i,
  input  logic [63:0]                seed_i,
  input  logic [2:0]                 sensor_kind_i,
  input  logic signed [63:0]         time_ns_i,
  input  logic [15:0]                tag_i,
  input  logic                       last_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [15:0]                out_tag_o,
  output logic [2:0]                 out_kind_o,
  output logic signed [63:0]         out_time_ns_o,
  output logic signed [63:0]         arrival_ns_o,
  output logic                       overflow_o,
  output logic                       out_last_o
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = pjr_pkg::MT_AW;
  localparam logic [AW-1:0] LAST_IDX = AW'(pjr_pkg::MT_N - 1);
  localparam logic [AW-1:0] WRAP_IDX = AW'(pjr_pkg::MT_N - pjr_pkg::MT_M);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_ITEMS);

  // Configuration registers.
  logic [63:0] kreg_q [pjr_pkg::NUM_KINDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pjr_pkg::NUM_KINDS; k++) begin
        kreg_q[k] <= pjr_pkg::kind_reset(3'(k));
      end
    end else if (cfg_we_i && (cfg_index_i < pjr_pkg::CFG_IW'(pjr_pkg::NUM_KINDS))) begin
      kreg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // Current item.
  logic               start_q, last_q;
  logic [63:0]        seed_q;
  logic [2:0]         kind_q;
  logic signed [63:0] time_q;
  logic [15:0]        tag_q;

  logic [63:0] kreg;
  logic [31:0] lag, jit;
  assign kreg = kreg_q[kind_q];
  assign lag  = kreg[31:0];
  assign jit  = kreg[63:32];

  // Generator memory and its sequencing registers.
  logic [63:0]   mt_mem [pjr_pkg::MT_N];
  logic [63:0]   mt_rd_q;
  logic [AW-1:0] mt_idx_q, pos_q, rd_addr, idx_p1, idx_pm;
  logic [63:0]   p_q, pp0_q, wa_q, wb_q;
  logic [31:0]   cross_q;
  logic [63:0]   sx, seed_word, tw_x, tw_word, y;
  logic          mt_we;
  logic [AW-1:0] mt_waddr;
  logic [63:0]   mt_wdata;

  assign idx_p1 = (mt_idx_q == LAST_IDX) ? '0 : mt_idx_q + AW'(1);
  assign idx_pm = (mt_idx_q >= WRAP_IDX) ? mt_idx_q - WRAP_IDX
                                         : mt_idx_q + AW'(pjr_pkg::MT_M);
  assign sx        = p_q ^ (p_q >> 62);
  assign seed_word = pp0_q + {cross_q, 32'h0} + 64'(mt_idx_q);
  assign tw_x      = (wa_q & pjr_pkg::MT_UPPER) | (wb_q & pjr_pkg::MT_LOWER);
  assign tw_word   = mt_rd_q ^ (tw_x >> 1) ^ (tw_x[0] ? pjr_pkg::MT_MATRIX : 64'h0);

  always_comb begin
    unique case (cmd_i)
      pjr_pkg::CMD_TW_RDA: rd_addr = mt_idx_q;
      pjr_pkg::CMD_TW_RDB: rd_addr = idx_p1;
      pjr_pkg::CMD_TW_RDC: rd_addr = idx_pm;
      default:             rd_addr = pos_q;
    endcase
  end

  always_comb begin
    mt_we    = 1'b0;
    mt_waddr = mt_idx_q;
    mt_wdata = tw_word;
    unique case (cmd_i)
      pjr_pkg::CMD_SEED_FIRST: begin
        mt_we    = 1'b1;
        mt_waddr = '0;
        mt_wdata = seed_q;
      end
      pjr_pkg::CMD_SEED_WRITE: begin
        mt_we    = 1'b1;
        mt_wdata = seed_word;
      end
      pjr_pkg::CMD_TW_WRITE: mt_we = 1'b1;
      default: mt_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mt_we) begin
      mt_mem[mt_waddr] <= mt_wdata;
    end
    mt_rd_q <= mt_mem[rd_addr];
  end

  // Tempering of the fetched word.
  always_comb begin
    y = mt_rd_q;
    y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
    y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
    y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
    y = y ^ (y >> 43);
  end

  // Residue mod 2049: 2^11 is -1 there, so 11-bit digits fold with alternating sign.
  logic [13:0] fold, t_q, rem;
  assign fold = pjr_pkg::FOLD_BIAS + 14'(y[10:0]) - 14'(y[21:11]) + 14'(y[32:22])
              - 14'(y[43:33]) + 14'(y[54:44]) - 14'(y[63:55]);

  always_comb begin
    rem = t_q;
    for (int k = 0; k < 5; k++) begin
      if (rem >= pjr_pkg::JITTER_SPAN) begin
        rem = rem - pjr_pkg::JITTER_SPAN;
      end
    end
  end

  logic signed [11:0] tick_q;
  logic signed [44:0] prod_q, q_s;
  logic signed [34:0] off_q, off_j;
  logic signed [64:0] sum;
  logic signed [63:0] arrival;

  // Division by 1024 that truncates toward zero.
  assign q_s   = prod_q[44] ? ((prod_q + 45'sd1023) >>> 10) : (prod_q >>> 10);
  assign off_j = $signed({3'b000, lag}) + $signed(q_s[34:0]);
  assign sum   = $signed({time_q[63], time_q}) + $signed({{30{off_q[34]}}, off_q});

  always_comb begin
    priority if (sum[64] != sum[63]) begin
      arrival = sum[64] ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}};
    end else begin
      arrival = sum[63:0];
    end
  end

  // Held items.
  logic signed [63:0] hv_time [MAX_ITEMS];
  logic signed [63:0] hv_arr  [MAX_ITEMS];
  logic [18:0]        hv_tk   [MAX_ITEMS];
  logic signed [63:0] arr_rd_q, tm_rd_q;
  logic [18:0]        tk_rd_q;
  logic [CW-1:0]      cnt_q, sc_j_q, em_cnt_q;
  logic               ovf_q, hv_we;
  logic [IW-1:0]      sc_k_q, best_idx_q, prev_idx_q;
  logic               sc_vld_q, best_found_q, first_q;
  logic signed [63:0] best_key_q, prev_key_q;
  logic               cand, better;

  assign hv_we = (cmd_i == pjr_pkg::CMD_STORE) && (cnt_q < MAX_CNT);

  always_ff @(posedge clk_i) begin
    if (hv_we) begin
      hv_time[cnt_q[IW-1:0]] <= time_q;
      hv_arr[cnt_q[IW-1:0]]  <= arrival;
      hv_tk[cnt_q[IW-1:0]]   <= {kind_q, tag_q};
    end
    arr_rd_q <= hv_arr[sc_j_q[IW-1:0]];
    tm_rd_q  <= hv_time[best_idx_q];
    tk_rd_q  <= hv_tk[best_idx_q];
  end

  assign cand   = first_q || (arr_rd_q > prev_key_q)
                  || ((arr_rd_q == prev_key_q) && (sc_k_q > prev_idx_q));
  assign better = !best_found_q || (arr_rd_q < best_key_q);

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      pjr_pkg::CMD_LOAD: begin
        seed_q <= seed_i;
        kind_q <= sensor_kind_i;
        time_q <= time_ns_i;
        tag_q  <= tag_i;
      end
      pjr_pkg::CMD_SEED_FIRST: p_q    <= seed_q;
      pjr_pkg::CMD_SEED_MUL0:  pp0_q  <= sx[31:0] * pjr_pkg::SEED_MULT[31:0];
      pjr_pkg::CMD_SEED_MUL1:  cross_q <= 32'(sx[31:0] * pjr_pkg::SEED_MULT[63:32]);
      pjr_pkg::CMD_SEED_MUL2:
        cross_q <= cross_q + 32'(sx[63:32] * pjr_pkg::SEED_MULT[31:0]);
      pjr_pkg::CMD_SEED_WRITE: p_q    <= seed_word;
      pjr_pkg::CMD_TW_RDB:     wa_q   <= mt_rd_q;
      pjr_pkg::CMD_TW_RDC:     wb_q   <= mt_rd_q;
      pjr_pkg::CMD_DR_TEMPER:  t_q    <= fold;
      pjr_pkg::CMD_DR_MOD:     tick_q <= $signed(rem[11:0] - pjr_pkg::JITTER_TICKS);
      pjr_pkg::CMD_DR_MUL:     prod_q <= tick_q * $signed({1'b0, jit});
      pjr_pkg::CMD_DR_OFFSET:  off_q  <= off_j;
      pjr_pkg::CMD_NOJIT:      off_q  <= $signed({3'b000, lag});
      default: ;
    endcase
  end

  // Control registers of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= 1'b0;
      last_q       <= 1'b0;
      mt_idx_q     <= '0;
      pos_q        <= '0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      sc_j_q       <= '0;
      sc_k_q       <= '0;
      sc_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_key_q   <= '0;
      prev_idx_q   <= '0;
      prev_key_q   <= '0;
      first_q      <= 1'b1;
      em_cnt_q     <= '0;
    end else begin
      unique case (cmd_i)
        pjr_pkg::CMD_LOAD: begin
          start_q  <= start_req_i;
          last_q   <= last_i;
          first_q  <= 1'b1;
          em_cnt_q <= '0;
        end
        pjr_pkg::CMD_SEED_FIRST: begin
          mt_idx_q <= AW'(1);
          cnt_q    <= '0;
          ovf_q    <= 1'b0;
        end
        pjr_pkg::CMD_SEED_WRITE: begin
          mt_idx_q <= idx_p1;
          if (mt_idx_q == LAST_IDX) begin
            pos_q <= AW'(pjr_pkg::MT_N);
          end
        end
        pjr_pkg::CMD_TW_WRITE: begin
          mt_idx_q <= idx_p1;
          if (mt_idx_q == LAST_IDX) begin
            pos_q <= '0;
          end
        end
        pjr_pkg::CMD_DR_TEMPER: pos_q <= pos_q + AW'(1);
        pjr_pkg::CMD_STORE: begin
          if (cnt_q < MAX_CNT) begin
            cnt_q <= cnt_q + CW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        pjr_pkg::CMD_SC_START: begin
          sc_j_q       <= '0;
          sc_vld_q     <= 1'b0;
          best_found_q <= 1'b0;
        end
        pjr_pkg::CMD_SC_STEP: begin
          if (sc_j_q < cnt_q) begin
            sc_vld_q <= 1'b1;
            sc_k_q   <= sc_j_q[IW-1:0];
            sc_j_q   <= sc_j_q + CW'(1);
          end else begin
            sc_vld_q <= 1'b0;
          end
          if (sc_vld_q && cand && better) begin
            best_found_q <= 1'b1;
            best_key_q   <= arr_rd_q;
            best_idx_q   <= sc_k_q;
          end
        end
        pjr_pkg::CMD_EMIT: begin
          prev_key_q <= best_key_q;
          prev_idx_q <= best_idx_q;
          first_q    <= 1'b0;
          em_cnt_q   <= em_cnt_q + CW'(1);
          if (stat_o.emit_last) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == pjr_pkg::CMD_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == pjr_pkg::CMD_EMIT) begin
      out_tag_o     <= tk_rd_q[15:0];
      out_kind_o    <= tk_rd_q[18:16];
      out_time_ns_o <= tm_rd_q;
      arrival_ns_o  <= best_key_q;
      overflow_o    <= ovf_q;
      out_last_o    <= stat_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.start      = start_q;
  assign stat_o.last       = last_q;
  assign stat_o.jit_nz     = (jit != 32'h0);
  assign stat_o.need_twist = (pos_q >= AW'(pjr_pkg::MT_N));
  assign stat_o.idx_last   = (mt_idx_q == LAST_IDX);
  assign stat_o.scan_done  = (sc_j_q == cnt_q) && !sc_vld_q;
  assign stat_o.emit_last  = ((em_cnt_q + CW'(1)) == cnt_q);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the per-source delay, jitter and reorder block.
// Needs only the block's RTL and pjr_pkg; predicts every sorted batch itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP      = 64;
  localparam int SETTLE   = 3000;  // covers a full generator refill or seeding pass
  localparam int LONG_HOLD = 400;

  // Register indexes of the kind lag/jitter registers.
  typedef enum logic [pjr_pkg::CFG_IW-1:0] {
    REG_KIND0, REG_KIND1, REG_KIND2, REG_KIND3,
    REG_KIND4, REG_KIND5, REG_KIND6, REG_KIND7
  } reg_idx_e;

  localparam logic signed [63:0] T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] T_MIN = 64'sh8000_0000_0000_0000;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [pjr_pkg::CFG_IW-1:0] cfg_index_i;
  logic [63:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic start_req_i, last_i;
  logic [63:0] seed_i;
  logic [2:0] sensor_kind_i;
  logic signed [63:0] time_ns_i;
  logic [15:0] tag_i;
  logic out_valid_o, out_stall_i;
  logic [15:0] out_tag_o;
  logic [2:0] out_kind_o;
  logic signed [63:0] out_time_ns_o, arrival_ns_o;
  logic overflow_o, out_last_o;

  per_source_delay_jitter_reorder u_dut (.*);

  // One emitted word of a sorted batch.
  typedef struct {
    logic [15:0]        tag;
    logic [2:0]         kind;
    logic signed [63:0] tstamp;
    logic signed [63:0] arrival;
    logic               ovf;
    logic               lst;
  } sorted_word_t;

  sorted_word_t due_words[$];
  int errors = 0;
  bit calm = 0;      // no random idling on either side while set
  bit hold_req = 0;  // receiver holds off for a long stretch at its next word

  // Bench copy of the block's state.
  logic [63:0]        kind_cfg[8];
  logic [63:0]        mt_words[312];
  int                 mt_pos;
  logic signed [63:0] buf_time[CAP];
  logic signed [63:0] buf_arr[CAP];
  logic [15:0]        buf_tag[CAP];
  logic [2:0]         buf_kind[CAP];
  int                 buf_count;
  bit                 buf_ovf;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // The 64-bit Mersenne Twister, as the block is expected to run it.
  function automatic void gen_seed(input logic [63:0] s);
    mt_words[0] = s;
    for (int i = 1; i < 312; i++)
      mt_words[i] = 64'd6364136223846793005 *
                    (mt_words[i-1] ^ (mt_words[i-1] >> 62)) + 64'(i);
    mt_pos = 312;
  endfunction

  function automatic logic [63:0] gen_draw();
    logic [63:0] x, y;
    if (mt_pos >= 312) begin
      for (int i = 0; i < 312; i++) begin
        x = (mt_words[i] & 64'hFFFF_FFFF_8000_0000) |
            (mt_words[(i+1)%312] & 64'h0000_0000_7FFF_FFFF);
        y = x >> 1;
        if (x[0]) y ^= 64'hB502_6F5A_A966_19E9;
        mt_words[i] = mt_words[(i+156)%312] ^ y;
      end
      mt_pos = 0;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y ^= (y >> 29) & 64'h5555_5555_5555_5555;
    y ^= (y << 17) & 64'h71D6_7FFF_EDA6_0000;
    y ^= (y << 37) & 64'hFFF7_EEE0_0000_0000;
    y ^= y >> 43;
    return y;
  endfunction

  // Applies one accepted word: skews its timestamp and, on last, queues the
  // stably sorted batch.
  function automatic void skew_and_sort(input bit st, input logic [63:0] sd,
                                        input logic [2:0] k, input logic signed [63:0] t,
                                        input logic [15:0] tg, input bit lst);
    longint lag, jit, tick, offset;
    logic signed [64:0] sum;
    int order[CAP];
    int j, cur;
    sorted_word_t w;
    if (st) begin
      buf_count = 0;
      buf_ovf = 0;
      gen_seed(sd);
    end
    lag = longint'({32'd0, kind_cfg[k][31:0]});
    jit = longint'({32'd0, kind_cfg[k][63:32]});
    offset = lag;
    if (jit != 0) begin
      tick = longint'(gen_draw() % 64'd2049) - 1024;
      offset += (tick * jit) / 1024;
    end
    if (buf_count < CAP) begin
      sum = 65'(t) + 65'(offset);
      buf_time[buf_count] = t;
      if (sum > 65'(T_MAX)) buf_arr[buf_count] = T_MAX;
      else if (sum < 65'(T_MIN)) buf_arr[buf_count] = T_MIN;
      else buf_arr[buf_count] = sum[63:0];
      buf_tag[buf_count] = tg;
      buf_kind[buf_count] = k;
      buf_count++;
    end else begin
      buf_ovf = 1;
    end
    if (!lst) return;
    for (int i = 0; i < buf_count; i++) begin
      cur = i;
      j = i;
      while (j > 0 && buf_arr[order[j-1]] > buf_arr[cur]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int i = 0; i < buf_count; i++) begin
      w.tag = buf_tag[order[i]];
      w.kind = buf_kind[order[i]];
      w.tstamp = buf_time[order[i]];
      w.arrival = buf_arr[order[i]];
      w.ovf = buf_ovf;
      w.lst = (i == buf_count - 1);
      due_words.insert(due_words.size(), w);
    end
    buf_count = 0;
    buf_ovf = 0;
  endfunction

  task automatic gap_cycles();
    int n;
    n = calm ? 0 : $urandom_range(0, 9);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Offers one measurement word and waits until the block takes it.
  task automatic send_word(input bit st, input logic [63:0] sd, input logic [2:0] k,
                           input logic signed [63:0] t, input logic [15:0] tg,
                           input bit lst);
    gap_cycles();
    in_valid_i <= 1'b1;
    start_req_i <= st;
    seed_i <= sd;
    sensor_kind_i <= k;
    time_ns_i <= t;
    tag_i <= tg;
    last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    skew_and_sort(st, sd, k, t, tg, lst);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    kind_cfg[idx] = val;
  endtask

  // Waits until the block has drained and settled, so registers may change.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (due_words.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {32'd0, $urandom};
      3: return {$urandom, $urandom};
      default: return {32'($urandom_range(0, 5000)), 32'($urandom_range(0, 3000))};
    endcase
  endfunction

  function automatic logic signed [63:0] pick_time();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return T_MAX - 64'($urandom_range(0, 3000));
      2: return T_MIN + 64'($urandom_range(0, 3000));
      default: return 64'($urandom_range(0, 4000)) - 64'sd2000;
    endcase
  endfunction

  // Receiver: random stall before each word, a long hold-off on request.
  initial begin
    int n;
    sorted_word_t e;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 9);
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (due_words.size() == 0) begin
        report($sformatf("unexpected word tag %h", out_tag_o));
      end else begin
        e = due_words.pop_front();
        if (out_tag_o !== e.tag)
          report($sformatf("tag %h, want %h", out_tag_o, e.tag));
        if (out_kind_o !== e.kind)
          report($sformatf("kind %0d, want %0d", out_kind_o, e.kind));
        if (out_time_ns_o !== e.tstamp)
          report($sformatf("time %0d, want %0d", out_time_ns_o, e.tstamp));
        if (arrival_ns_o !== e.arrival)
          report($sformatf("arrival %0d, want %0d", arrival_ns_o, e.arrival));
        if (overflow_o !== e.ovf)
          report($sformatf("overflow %b, want %b", overflow_o, e.ovf));
        if (out_last_o !== e.lst)
          report($sformatf("last %b, want %b", out_last_o, e.lst));
      end
    end
  end

  // Directed rows. Where typed is set the row ends a one-word batch whose
  // arrival can be read off directly; the typed word replaces the prediction.
  typedef struct {
    int                 ph;
    bit                 st;
    logic [63:0]        sd;
    logic [2:0]         k;
    logic signed [63:0] t;
    logic [15:0]        tg;
    bit                 lst;
    bit                 typed;
    logic signed [63:0] arr;
  } row_t;

  row_t rows[] = '{
    // Zero-jitter kinds before any seeding: arrival equals the timestamp.
    '{1, 0, 64'd0, 3'd0, T_MAX, 16'hFFFF, 1, 1, T_MAX},
    '{1, 0, 64'd0, 3'd6, T_MIN, 16'h0000, 1, 1, T_MIN},
    '{1, 0, 64'd0, 3'd0, 64'sd0, 16'h0003, 0, 0, 0},
    '{1, 0, 64'd0, 3'd6, -64'sd5, 16'h0004, 1, 0, 0},
    // Seeded batch through every kind, with two equal arrivals at the end.
    '{1, 1, 64'd0, 3'd1, 64'sd1000, 16'h0011, 0, 0, 0},
    '{1, 0, 64'd0, 3'd2, 64'sd1000, 16'h0012, 0, 0, 0},
    '{1, 0, 64'd0, 3'd3, 64'sd2000, 16'h0013, 0, 0, 0},
    '{1, 0, 64'd0, 3'd4, -64'sd1000, 16'h0014, 0, 0, 0},
    '{1, 0, 64'd0, 3'd5, 64'sd0, 16'h0015, 0, 0, 0},
    '{1, 0, 64'd0, 3'd7, 64'sd300, 16'h0016, 0, 0, 0},
    '{1, 0, 64'd0, 3'd0, 64'sd77, 16'h0017, 0, 0, 0},
    '{1, 0, 64'd0, 3'd6, 64'sd77, 16'h0018, 1, 0, 0},
    '{1, 1, '1, 3'd7, T_MAX, 16'h0021, 1, 0, 0},
    '{1, 1, 64'h0123_4567_89AB_CDEF, 3'd1, T_MIN, 16'h0022, 1, 0, 0},
    // Extreme registers: saturation both ways and the full jitter width.
    '{2, 1, 64'd5489, 3'd0, T_MAX, 16'h0031, 1, 1, T_MAX},
    '{2, 0, 64'd0, 3'd1, T_MIN, 16'h0032, 0, 0, 0},
    '{2, 0, 64'd0, 3'd2, T_MIN, 16'h0033, 0, 0, 0},
    '{2, 0, 64'd0, 3'd2, T_MAX, 16'h0034, 0, 0, 0},
    '{2, 0, 64'd0, 3'd3, 64'sd9, 16'h0035, 0, 0, 0},
    '{2, 0, 64'd0, 3'd4, 64'sd9, 16'h0036, 0, 0, 0},
    '{2, 0, 64'd0, 3'd5, -64'sd1, 16'h0037, 0, 0, 0},
    '{2, 0, 64'd0, 3'd7, 64'sd1, 16'h0038, 1, 0, 0}
  };

  initial begin
    int items, blen, ph;
    bit st;
    logic [63:0] sd;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    start_req_i = 1'b0;
    seed_i = '0;
    sensor_kind_i = '0;
    time_ns_i = '0;
    tag_i = '0;
    last_i = 1'b0;
    for (int i = 0; i < 8; i++) kind_cfg[i] = pjr_pkg::kind_reset(3'(i));
    for (int i = 0; i < 312; i++) mt_words[i] = '0;
    mt_pos = 0;
    buf_count = 0;
    buf_ovf = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    ph = 1;
    foreach (rows[r]) begin
      if (rows[r].ph != ph) begin
        drain();
        write_reg(REG_KIND0, 64'h0000_0000_FFFF_FFFF);
        write_reg(REG_KIND1, '1);
        write_reg(REG_KIND2, 64'hFFFF_FFFF_0000_0000);
        write_reg(REG_KIND3, 64'd0);
        write_reg(REG_KIND4, 64'h0000_0001_0000_0000);
        write_reg(REG_KIND5, 64'h0000_0400_0000_0001);
        write_reg(REG_KIND6, 64'h8000_0000_8000_0000);
        write_reg(REG_KIND7, 64'h0000_0003_0000_0000);
        cfg_valid_i <= 1'b0;
        ph = rows[r].ph;
      end
      send_word(rows[r].st, rows[r].sd, rows[r].k, rows[r].t, rows[r].tg, rows[r].lst);
      if (rows[r].typed) begin
        due_words[$].tag = rows[r].tg;
        due_words[$].kind = rows[r].k;
        due_words[$].tstamp = rows[r].t;
        due_words[$].arrival = rows[r].arr;
        due_words[$].ovf = 1'b0;
        due_words[$].lst = 1'b1;
      end
    end

    // Random batches under three register settings. The generator is already
    // seeded, so batches without a start are legal.
    for (int p = 0; p < 3; p++) begin
      drain();
      for (int i = 0; i < 8; i++) write_reg(reg_idx_e'(i), p == 2 ? 64'd0 : pick_reg());
      cfg_valid_i <= 1'b0;
      items = 0;
      while (items < 20) begin
        calm = ($urandom_range(0, 4) == 0);
        blen = (p == 1 && items == 0) ? CAP + 2 : $urandom_range(1, 12);
        if (p == 1 && items == 0) hold_req = 1;
        sd = {$urandom, $urandom};
        st = ($urandom_range(0, 1) == 1) || blen > CAP;
        for (int b = 0; b < blen; b++) begin
          // A stray start inside a batch throws away what was held.
          send_word(b == 0 ? st : ($urandom_range(0, 19) == 0), sd,
                    3'($urandom_range(0, 7)), pick_time(), 16'($urandom),
                    b == blen - 1);
          items++;
        end
        // Now and then the sender waits for the whole batch to come out.
        if ($urandom_range(0, 3) == 0) begin
          in_valid_i <= 1'b0;
          wait (due_words.size() == 0);
        end
      end
    end
    calm = 0;
    in_valid_i <= 1'b0;

    wait (due_words.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pjr_pkg.sv
hdl/pjr_ctrl.sv
hdl/pjr_dp.sv
hdl/per_source_delay_jitter_reorder.sv
bench/tb_top.sv
